FILE: src/fcd_pkg.sv
// Package for the forest cycle detector: constants, codes, payload types and the state type.
package fcd_pkg;

  localparam int FCD_NODES      = 65536;
  localparam int FCD_MAX_PATH   = 512;
  localparam int FCD_MAX_CYCLES = 64;

  localparam logic [10:0] PROOF_LEN_RESET = 11'd42;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  typedef struct packed {
    logic [14:0] u_edge_end;
    logic [14:0] v_edge_end;
  } fcd_in_t;

  typedef struct packed {
    logic        cycle_found;
    logic [10:0] cycle_length;
    logic [5:0]  cycle_slot;
    logic        is_solution;
    logic [1:0]  status;
  } fcd_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DECIDE,
    ST_ROOT_WR,
    ST_LEN_RD,
    ST_LEN_CHK,
    ST_RECORD,
    ST_LINK_RD,
    ST_LINK_WR,
    ST_DONE
  } fcd_state_t;

endpackage

FILE: src/forest_cycle_detector.sv
// Top level of the forest cycle detector.
// After reset the block clears the path counts and takes no edge meanwhile.
// An edge then walks both of its ends to their roots (one node per cycle on the
// forest memory read port), then runs the cycle length search when the roots
// match, or reverses and relinks a path otherwise; one edge is worked on at a
// time. A finished result sits in the output register while the next edge is
// accepted.
module forest_cycle_detector #(
  parameter int NODES      = fcd_pkg::FCD_NODES,
  parameter int MAX_PATH   = fcd_pkg::FCD_MAX_PATH,
  parameter int MAX_CYCLES = fcd_pkg::FCD_MAX_CYCLES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcd_pkg::fcd_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fcd_pkg::fcd_out_t out_data,
  input  logic             cfg_we,
  input  logic [10:0]      cfg_wdata
);
  import fcd_pkg::*;

  localparam int NW  = $clog2(NODES);
  localparam int PW  = $clog2(MAX_PATH);
  localparam int PCW = $clog2(MAX_PATH + 1);
  localparam int CW  = (MAX_CYCLES > 1) ? $clog2(MAX_CYCLES) : 1;
  localparam int TW  = $clog2(MAX_CYCLES + 1);

  fcd_state_t state, state_next;

  logic [NW-1:0] node, u_node, v_node, u_root, v_root, cur, clr_addr;
  logic [PW-1:0] pos, ui, vi, a, b, k;
  logic          side, sel_v;
  logic [TW-1:0] cycle_total;
  logic [10:0]   proof_len;
  fcd_out_t      res;

  logic [NW-1:0] rd_addr, par_rdata, par_waddr, par_wdata, cnt_waddr;
  logic          par_we, cnt_we;
  logic [31:0]   cnt_rdata, cnt_wdata;

  logic          up_we, vp_we;
  logic [PW-1:0] up_wa, vp_wa, up_ra, vp_ra;
  logic [NW-1:0] up_wd, vp_wd, up_q, vp_q;
  logic [NW-1:0] up_mem [MAX_PATH];
  logic [NW-1:0] vp_mem [MAX_PATH];

  logic [NW-1:0] ce_u_mem [MAX_CYCLES];
  logic [NW-1:0] ce_v_mem [MAX_CYCLES];
  logic [10:0]   cl_mem   [MAX_CYCLES];

  logic [NW-1:0] u_in, v_in;
  logic [PCW-1:0] pos_inc;
  logic           accept, cnt_nz, overflow, full, out_load;
  logic [10:0]    len;
  logic [PW-1:0]  shift;

  assign u_in    = NW'({in_data.u_edge_end, 1'b0});
  assign v_in    = NW'({in_data.v_edge_end, 1'b1});
  assign accept  = in_valid && in_ready;
  assign cnt_nz  = cnt_rdata != 32'd0;
  assign pos_inc = {1'b0, pos} + PCW'(1);
  assign overflow = pos_inc >= PCW'(MAX_PATH);
  assign full    = 32'(cycle_total) >= 32'(MAX_CYCLES);
  assign len     = 11'(32'(a) + 32'(b) + 32'd1);
  assign shift   = (ui < vi) ? ui : vi;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  fcd_forest_mem #(.NODES(NODES)) u_forest (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .par_we   (par_we),
    .par_waddr(par_waddr),
    .par_wdata(par_wdata),
    .cnt_we   (cnt_we),
    .cnt_waddr(cnt_waddr),
    .cnt_wdata(cnt_wdata),
    .par_rdata(par_rdata),
    .cnt_rdata(cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (up_we) begin
      up_mem[up_wa] <= up_wd;
    end
    if (vp_we) begin
      vp_mem[vp_wa] <= vp_wd;
    end
    up_q <= up_mem[up_ra];
    vp_q <= vp_mem[vp_ra];
  end

  always_ff @(posedge clk) begin
    if (state == ST_RECORD && !full) begin
      ce_u_mem[CW'(cycle_total)] <= u_node;
      ce_v_mem[CW'(cycle_total)] <= v_node;
      cl_mem[CW'(cycle_total)]   <= len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_addr    = node;
    par_we     = 1'b0;
    par_waddr  = cur;
    par_wdata  = sel_v ? vp_q : up_q;
    cnt_we     = 1'b0;
    cnt_waddr  = node;
    cnt_wdata  = cnt_rdata + 32'd1;
    up_we      = 1'b0;
    vp_we      = 1'b0;
    up_wa      = pos_inc[PW-1:0];
    vp_wa      = pos_inc[PW-1:0];
    up_wd      = par_rdata;
    vp_wd      = par_rdata;
    up_ra      = a;
    vp_ra      = b;
    case (state)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = 32'd0;
        if (clr_addr == NW'(NODES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = u_in;
        up_wa    = '0;
        up_wd    = u_in;
        if (accept) begin
          up_we      = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cnt_nz) begin
          cnt_we  = 1'b1;
          rd_addr = par_rdata;
          if (overflow) begin
            state_next = ST_DONE;
          end else begin
            up_we = !side;
            vp_we = side;
          end
        end else if (!side) begin
          rd_addr = v_node;
          vp_we   = 1'b1;
          vp_wa   = '0;
          vp_wd   = v_node;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        rd_addr = (ui < vi) ? u_root : v_root;
        if (u_root == v_root) begin
          state_next = ST_LEN_RD;
        end else begin
          state_next = ST_ROOT_WR;
        end
      end
      ST_ROOT_WR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = cur;
        state_next = ST_LINK_RD;
      end
      ST_LEN_RD: begin
        if (a < ui) begin
          state_next = ST_LEN_CHK;
        end else begin
          state_next = ST_RECORD;
        end
      end
      ST_LEN_CHK: begin
        if (up_q != vp_q) begin
          state_next = ST_LEN_RD;
        end else begin
          state_next = ST_RECORD;
        end
      end
      ST_RECORD: begin
        state_next = ST_DONE;
      end
      ST_LINK_RD: begin
        up_ra = k - PW'(1);
        vp_ra = k - PW'(1);
        if (k == '0) begin
          par_we     = 1'b1;
          par_waddr  = sel_v ? v_node : u_node;
          par_wdata  = sel_v ? u_node : v_node;
          state_next = ST_DONE;
        end else begin
          state_next = ST_LINK_WR;
        end
      end
      ST_LINK_WR: begin
        par_we     = 1'b1;
        state_next = ST_LINK_RD;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_CLEAR: begin
        clr_addr <= clr_addr + NW'(1);
      end
      ST_IDLE: begin
        node   <= u_in;
        u_node <= u_in;
        v_node <= v_in;
        pos    <= '0;
        side   <= 1'b0;
        res    <= '0;
      end
      ST_WALK: begin
        if (cnt_nz) begin
          node <= par_rdata;
          pos  <= pos_inc[PW-1:0];
          if (overflow) begin
            res.status <= STAT_OVERFLOW;
          end
        end else if (!side) begin
          u_root <= node;
          ui     <= pos;
          node   <= v_node;
          pos    <= '0;
          side   <= 1'b1;
        end else begin
          v_root <= node;
          vi     <= pos;
        end
      end
      ST_DECIDE: begin
        a     <= ui - shift;
        b     <= vi - shift;
        sel_v <= !(ui < vi);
        k     <= (ui < vi) ? ui : vi;
        cur   <= (ui < vi) ? u_root : v_root;
        ui    <= ui;
      end
      ST_LEN_CHK: begin
        if (up_q != vp_q) begin
          a <= a + PW'(1);
          b <= b + PW'(1);
        end
      end
      ST_RECORD: begin
        res.cycle_found  <= 1'b1;
        res.cycle_length <= len;
        res.is_solution  <= (len == proof_len);
        if (!full) begin
          res.cycle_slot <= 6'(cycle_total);
          res.status     <= (32'(cycle_total) + 32'd1 >= 32'(MAX_CYCLES)) ? STAT_FULL
                                                                         : STAT_OK;
        end else begin
          res.cycle_slot <= '0;
          res.status     <= STAT_FULL;
        end
      end
      ST_LINK_WR: begin
        cur <= sel_v ? vp_q : up_q;
        k   <= k - PW'(1);
      end
      default: begin
      end
    endcase
    if (rst) begin
      clr_addr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_total <= '0;
    end else if (state == ST_RECORD && !full) begin
      cycle_total <= cycle_total + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proof_len <= PROOF_LEN_RESET;
    end else if (cfg_we) begin
      proof_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule

FILE: src/fcd_forest_mem.sv
// Forest memories: parent links and path counts, shared read address, count bypass.
module fcd_forest_mem #(
  parameter int NODES = fcd_pkg::FCD_NODES
) (
  input  logic                     clk,
  input  logic [$clog2(NODES)-1:0] rd_addr,
  input  logic                     par_we,
  input  logic [$clog2(NODES)-1:0] par_waddr,
  input  logic [$clog2(NODES)-1:0] par_wdata,
  input  logic                     cnt_we,
  input  logic [$clog2(NODES)-1:0] cnt_waddr,
  input  logic [31:0]              cnt_wdata,
  output logic [$clog2(NODES)-1:0] par_rdata,
  output logic [31:0]              cnt_rdata
);
  localparam int NW = $clog2(NODES);

  logic [NW-1:0] par_mem [NODES];
  logic [31:0]   cnt_mem [NODES];
  logic [31:0]   cnt_q;
  logic          byp;
  logic [31:0]   byp_data;

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rdata <= par_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q    <= cnt_mem[rd_addr];
    byp      <= cnt_we && (cnt_waddr == rd_addr);
    byp_data <= cnt_wdata;
  end

  assign cnt_rdata = byp ? byp_data : cnt_q;

endmodule

FILE: src/fcd_checker.sv
// Port-level checks for the forest cycle detector, bound to the top level.
module fcd_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input fcd_pkg::fcd_out_t out_data
);
  import fcd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STAT_OVERFLOW |->
      !out_data.cycle_found && out_data.cycle_length == 11'd0 &&
      out_data.cycle_slot == 6'd0 && !out_data.is_solution)
    else $error("overflow result carries cycle fields");

  a_no_cycle_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.cycle_found |->
      out_data.cycle_length == 11'd0 && !out_data.is_solution &&
      out_data.status != STAT_FULL)
    else $error("cycle fields set without a cycle");

endmodule

bind forest_cycle_detector fcd_checker u_fcd_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

FILE: sim/forest_cycle_detector_tb.sv
// Testbench for forest_cycle_detector: directed and random edges checked against a predictor.
`timescale 1ns / 1ps

module forest_cycle_detector_tb;
  import fcd_pkg::*;

  localparam int CHAIN_BASE = 10000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  fcd_in_t in_data;
  logic out_valid;
  logic out_ready;
  fcd_out_t out_data;
  logic cfg_we;
  logic [10:0] cfg_wdata;

  bit [15:0] parent_of [FCD_NODES];
  bit [31:0] visits [FCD_NODES];
  bit [15:0] u_trail [FCD_MAX_PATH];
  bit [15:0] v_trail [FCD_MAX_PATH];
  bit [6:0] cycles_logged;
  bit [10:0] proof_len;

  fcd_out_t pending_results[$];
  int error_count;
  bit steady_send;
  bit steady_drain;

  forest_cycle_detector i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit trace_root(bit on_v, bit [15:0] start, output int last);
    bit [15:0] node;
    int pos;
    node = start;
    pos = 0;
    if (on_v) v_trail[0] = node; else u_trail[0] = node;
    while (visits[node] != 0) begin
      visits[node] = visits[node] + 1;
      node = parent_of[node];
      pos++;
      if (pos >= FCD_MAX_PATH) return 1'b1;
      if (on_v) v_trail[pos] = node; else u_trail[pos] = node;
    end
    last = pos;
    return 1'b0;
  endfunction

  function automatic void reverse_path(bit on_v, int last, bit [15:0] from, bit [15:0] to);
    bit [15:0] tip;
    tip = on_v ? v_trail[last] : u_trail[last];
    visits[tip] = visits[tip] + 1;
    for (int k = last; k > 0; k--) begin
      if (on_v) parent_of[v_trail[k]] = v_trail[k-1];
      else parent_of[u_trail[k]] = u_trail[k-1];
    end
    parent_of[from] = to;
  endfunction

  function automatic fcd_out_t predict_edge(fcd_in_t e);
    fcd_out_t res;
    bit [15:0] un;
    bit [15:0] vn;
    int ui;
    int vi;
    int a;
    int b;
    int shift;
    bit [10:0] len;
    res = '0;
    un = {e.u_edge_end, 1'b0};
    vn = {e.v_edge_end, 1'b1};
    ui = 0;
    vi = 0;
    if (trace_root(1'b0, un, ui) || trace_root(1'b1, vn, vi)) begin
      res.status = STAT_OVERFLOW;
      return res;
    end
    if (u_trail[ui] == v_trail[vi]) begin
      shift = (ui < vi) ? ui : vi;
      a = ui - shift;
      b = vi - shift;
      while (a < ui && b < vi && u_trail[a] != v_trail[b]) begin
        a++;
        b++;
      end
      len = 11'(a + b + 1);
      res.cycle_found = 1'b1;
      res.cycle_length = len;
      res.is_solution = (len == proof_len);
      if (cycles_logged < FCD_MAX_CYCLES) begin
        res.cycle_slot = cycles_logged[5:0];
        cycles_logged = cycles_logged + 1;
        res.status = (cycles_logged >= FCD_MAX_CYCLES) ? STAT_FULL : STAT_OK;
      end else begin
        res.status = STAT_FULL;
      end
    end else if (ui < vi) begin
      reverse_path(1'b0, ui, un, vn);
    end else begin
      reverse_path(1'b1, vi, vn, un);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_edge(int ub, int vb);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{u_edge_end: 15'(ub), v_edge_end: 15'(vb)};
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_edge('{u_edge_end: 15'(ub), v_edge_end: 15'(vb)}));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_proof_length(int value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= 11'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    proof_len = 11'(value);
  endtask

  // transfer check and random output stalls
  int stall_left;
  always @(posedge clk) begin
    fcd_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_data.cycle_found !== want.cycle_found)
          report_mismatch("cycle_found", out_data.cycle_found, want.cycle_found);
        if (out_data.cycle_length !== want.cycle_length)
          report_mismatch("cycle_length", out_data.cycle_length, want.cycle_length);
        if (out_data.cycle_slot !== want.cycle_slot)
          report_mismatch("cycle_slot", out_data.cycle_slot, want.cycle_slot);
        if (out_data.is_solution !== want.is_solution)
          report_mismatch("is_solution", out_data.is_solution, want.is_solution);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
    if (steady_drain) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  task automatic test_extremes();
    send_edge(0, 0);
    send_edge(0, 0);
    send_edge(32767, 32767);
    send_edge(32767, 0);
    send_edge(0, 32767);
    send_edge(32767, 32767);
    send_edge(15'h5555, 15'h2AAA);
    send_edge(15'h2AAA, 15'h5555);
    send_edge(1, 1);
    send_edge(2, 1);
    send_edge(2, 2);
    send_edge(1, 2);
  endtask

  task automatic test_proof_lengths();
    set_proof_length(2);
    send_edge(3, 3);
    send_edge(3, 3);
    set_proof_length(1024);
    send_edge(3, 3);
    set_proof_length(4);
    send_edge(2, 1);
    send_edge(1, 2);
  endtask

  task automatic test_long_path();
    steady_send = 1'b1;
    for (int i = 0; i < 260; i++) begin
      send_edge(CHAIN_BASE + i, CHAIN_BASE + i);
      send_edge(CHAIN_BASE + i + 1, CHAIN_BASE + i);
    end
    steady_send = 1'b0;
    send_edge(CHAIN_BASE + 260, 30000);
    send_edge(20000, CHAIN_BASE + 259);
    send_edge(CHAIN_BASE + 10, CHAIN_BASE + 12);
  endtask

  task automatic test_random();
    int w;
    for (int phase = 0; phase < 4; phase++) begin
      set_proof_length($urandom_range(2, 12));
      steady_send = (phase == 1);
      steady_drain = (phase == 2);
      for (int n = 0; n < 78; n++) begin
        w = $urandom_range(0, 99);
        if (w < 85) send_edge(64 + $urandom_range(0, 12), 64 + $urandom_range(0, 12));
        else send_edge($urandom_range(0, 32767), $urandom_range(0, 32767));
      end
    end
    steady_send = 1'b0;
    steady_drain = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    stall_left = 0;
    error_count = 0;
    steady_send = 1'b0;
    steady_drain = 1'b0;
    cycles_logged = '0;
    proof_len = PROOF_LEN_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_proof_lengths();
    test_long_path();
    test_random();
    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
